// File: design/bchr_pkg.sv
package bchr_pkg;

	// counter and threshold width
	localparam int unsigned CntW  = 16;
	localparam int unsigned PinW  = 16;
	localparam int unsigned DataW = 16;
	localparam int unsigned IdxW  = 2;

	localparam logic [CntW-1:0] CntMax = '1;

	// register indexes
	localparam logic [IdxW-1:0] RegBounce = 2'd0;
	localparam logic [IdxW-1:0] RegHold   = 2'd1;
	localparam logic [IdxW-1:0] RegRepeat = 2'd2;

	// register reset values
	localparam logic [CntW-1:0] DefBounce = 16'd25;
	localparam logic [CntW-1:0] DefHold   = 16'd400;
	localparam logic [CntW-1:0] DefRepeat = 16'd400;

	// button phase
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HELD   = 2'd1,
		PH_REPEAT = 2'd2
	} phase_t;

	// thresholds shared by all lanes
	typedef struct packed {
		logic [CntW-1:0] bounce;
		logic [CntW-1:0] hold;
		logic [CntW-1:0] rpt;
	} cfg_t;

	// events of one button for one tick
	typedef struct packed {
		logic click;
		logic hold;
		logic rpt;
	} evt_t;

endpackage

// File: design/bchr_lane.sv
module bchr_lane (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           pressed,
	input  bchr_pkg::cfg_t cfg,
	output bchr_pkg::evt_t evt
);
	import bchr_pkg::*;

	phase_t          phase_q, phase_n;
	logic [CntW-1:0] deb_q, deb_n, deb_inc;
	logic [CntW-1:0] ret_q, ret_n, ret_inc;

	// saturating increments
	assign deb_inc = (deb_q == CntMax) ? CntMax : deb_q + 1'b1;
	assign ret_inc = (ret_q == CntMax) ? CntMax : ret_q + 1'b1;

	// next state of the button
	always_comb begin
		phase_n = phase_q;
		deb_n   = '0;
		ret_n   = '0;
		if (pressed) begin
			deb_n = deb_inc;
			ret_n = ret_q;
			case (phase_q)
				PH_IDLE: begin
					if (deb_inc > cfg.bounce) begin
						phase_n = PH_HELD;
					end
				end
				PH_HELD: begin
					ret_n = ret_inc;
					if (ret_inc > cfg.hold) begin
						ret_n   = '0;
						phase_n = PH_REPEAT;
					end
				end
				PH_REPEAT: begin
					ret_n = ret_inc;
					if (ret_inc > cfg.rpt) begin
						ret_n = '0;
					end
				end
				default: begin
					ret_n = ret_q;
				end
			endcase
		end else begin
			phase_n = PH_IDLE;
		end
	end

	// events of this tick
	always_comb begin
		evt = '0;
		if (pressed) begin
			case (phase_q)
				PH_IDLE:   evt.click = (deb_inc > cfg.bounce);
				PH_HELD:   evt.hold  = (ret_inc > cfg.hold);
				PH_REPEAT: evt.rpt   = (ret_inc > cfg.rpt);
				default:   evt       = '0;
			endcase
		end
	end

	// state update once per transfer to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			deb_q   <= '0;
			ret_q   <= '0;
		end else if (en) begin
			phase_q <= phase_n;
			deb_q   <= deb_n;
			ret_q   <= ret_n;
		end
	end

endmodule

// File: design/button_click_hold_repeat_core.sv
// Pipeline: input register, then result register.
// Throughput: one tick per cycle while out_stall is low;
// every button lane updates in parallel in one pass.
// While a result waits on out_stall the input register takes one more tick, then in_stall rises.
// Reset (arst_n low, asynchronous): all buttons idle, counters zero, pipeline empty,
// thresholds back to 25 / 400 / 400 ticks.
module button_click_hold_repeat_core #(
	parameter int unsigned NUM_BUTTONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bchr_pkg::IdxW-1:0]      cfg_index,
	input  logic [bchr_pkg::DataW-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bchr_pkg::PinW-1:0]      pin_levels,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bchr_pkg::PinW-1:0]      click_events,
	output logic [bchr_pkg::PinW-1:0]      hold_events,
	output logic [bchr_pkg::PinW-1:0]      repeat_events
);
	import bchr_pkg::*;

	// buttons past the input width never see a press, so they need no lane
	localparam int unsigned Lanes = (NUM_BUTTONS < PinW) ? NUM_BUTTONS : PinW;

	cfg_t            cfg_q;
	logic            valid_s1, valid_s2;
	logic [PinW-1:0] pin_s1;
	logic [PinW-1:0] click_s2, hold_s2, rpt_s2;
	logic [PinW-1:0] click_d, hold_d, rpt_d;
	logic            out_free, adv, in_xfer;

	// handshake
	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bounce <= DefBounce;
			cfg_q.hold   <= DefHold;
			cfg_q.rpt    <= DefRepeat;
		end else if (cfg_we) begin
			case (cfg_index)
				RegBounce: cfg_q.bounce <= cfg_data;
				RegHold:   cfg_q.hold   <= cfg_data;
				RegRepeat: cfg_q.rpt    <= cfg_data;
				default:   cfg_q        <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pin_s1 <= pin_levels;
		end
	end

	// one lane per button
	for (genvar i = 0; i < PinW; i++) begin : g_lane
		if (i < Lanes) begin : g_on
			evt_t evt;

			bchr_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (adv),
				.pressed (!pin_s1[i]),
				.cfg     (cfg_q),
				.evt     (evt)
			);

			assign click_d[i] = evt.click;
			assign hold_d[i]  = evt.hold;
			assign rpt_d[i]   = evt.rpt;
		end else begin : g_off
			assign click_d[i] = 1'b0;
			assign hold_d[i]  = 1'b0;
			assign rpt_d[i]   = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			click_s2 <= click_d;
			hold_s2  <= hold_d;
			rpt_s2   <= rpt_d;
		end
	end

	assign out_valid     = valid_s2;
	assign click_events  = click_s2;
	assign hold_events   = hold_s2;
	assign repeat_events = rpt_s2;

	// a button fires at most one kind of event per tick
	a_evt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (((click_s2 & hold_s2) | (click_s2 & rpt_s2) | (hold_s2 & rpt_s2)) == '0))
	else $error("more than one event kind for one button");

	// a new result only comes from a filled input register
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
	else $error("result without a tick in the input register");

	// stall upstream only when the input register is occupied
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
	else $error("input stalled with room in the pipeline");

endmodule
